@@ sv/pasi_pkg.sv @@
// Shared types and codes of the polar angle sorted vertex table.
`default_nettype none
package pasi_pkg;

	localparam int COORD_W = 25;           // coordinate width, unsigned
	localparam int DIFF_W  = COORD_W + 1;  // coordinate minus center, signed
	localparam int PROD_W  = 2 * DIFF_W;   // full product of two differences
	localparam int IDX_IN_W = 4;           // read_index field width
	localparam int OUT_IDX_W = 5;          // position / vertex_count field width

	localparam int S_TDATA_W = 56;         // point_x, point_y, read_index, pad
	localparam int M_TDATA_W = 64;         // position, vertex_count, entry_x, entry_y, pad
	localparam int OP_W = 2;

	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic [PROD_W-1:0]         mag_t;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	// configuration register indexes
	localparam logic REG_CENTER_X = 1'b0;
	localparam logic REG_CENTER_Y = 1'b1;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_CLEARED   = 3'd3,
		ST_READ_OK   = 3'd4,
		ST_BEYOND    = 3'd5
	} status_t;

endpackage
`default_nettype wire

@@ sv/polar_angle_sorted_insert_core.sv @@
// Top level: polar angle ordered vertex table with its scan and shift sequencer.
`default_nettype none
// Keeps up to MAX_VERTICES points sorted by polar angle around the center held in
// the center_x / center_y registers; one word in gives one word out. An item is taken
// only while the sequencer is idle. An insert into an empty table goes straight to
// storing the point. Any other insert first squares the new point's distance, then
// for each entry scanned lets the half plane or the x axis rule decide, else the
// cross product, else on an exact angle tie the squared distances; it then moves
// entries back one at a time and stores the point. These steps are serialised by the
// one shared 26x26 multiplier, which serves every product in turn, and by the single
// read port of the vertex RAM, which holds x and y of one entry per word. The
// scan stops at the first entry that is neither ahead of nor equal to the new point;
// an equal entry ends it with a duplicate report. On a full table the scan runs the
// same way and the item is dropped where it would have gone in.
// Results wait in an output register, so the next word may be sent while a result
// is still pending.
module polar_angle_sorted_insert_core #(
	parameter int MAX_VERTICES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: index 0 center_x, index 1 center_y
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [24:0] cfg_data,
	// input words
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [55:0] s_tdata,   // point_x[24:0], point_y[49:25], read_index[53:50]
	input  wire logic [1:0]  s_tuser,   // opcode[1:0]
	// result words
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [63:0] m_tdata,   // position[4:0], vertex_count[9:5],
	                                    // entry_x[34:10], entry_y[59:35]
	output      logic [2:0]  m_tuser    // status[2:0]
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int CMP_W = (CNT_W > pasi_pkg::IDX_IN_W) ? CNT_W : pasi_pkg::IDX_IN_W;
	localparam int CW    = pasi_pkg::COORD_W;
	localparam int DW    = pasi_pkg::DIFF_W;

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_MB0    = 17'h00002,  // bx*bx
		S_MB1    = 17'h00004,  // by*by
		S_MB2    = 17'h00008,  // sum -> |b|^2
		S_RD     = 17'h00010,  // fetch entry
		S_LD     = 17'h00020,  // entry minus center
		S_CMP    = 17'h00040,  // equality, half plane, axis rule
		S_X1     = 17'h00080,  // ax*by arrives
		S_X2     = 17'h00100,  // ay*bx arrives, cross compare
		S_M1     = 17'h00200,  // ax*ax arrives
		S_M2     = 17'h00400,  // ay*ay arrives
		S_M3     = 17'h00800,  // |a|^2 vs |b|^2
		S_SH_RD  = 17'h01000,
		S_SH_WR  = 17'h02000,
		S_PLACE  = 17'h04000,
		S_RDWAIT = 17'h08000,
		S_DONE   = 17'h10000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             m_tvalid_q;
	pasi_pkg::coord_t cx_q, cy_q;

	// datapath registers
	pasi_pkg::coord_t px_q, py_q;
	pasi_pkg::diff_t  bx_q, by_q, ax_q, ay_q;
	logic             same_q;
	pasi_pkg::prod_t  t_q;
	pasi_pkg::mag_t   ma_q, mb_q;
	logic [CNT_W-1:0] idx_q, ins_pos_q, sh_q;
	pasi_pkg::status_t res_status_q;
	logic [CMP_W-1:0] res_pos_q;
	pasi_pkg::coord_t res_x_q, res_y_q;
	logic [2:0]       m_tuser_q;
	logic [63:0]      m_tdata_q;

	// input word fields
	logic [1:0]       in_op;
	pasi_pkg::coord_t in_x, in_y;
	logic [3:0]       in_ridx;
	logic             in_fire;
	logic [CMP_W-1:0] ridx_ext;
	logic             rd_ok;

	// scan decision
	logic             decide, ahead, idx_last, full;
	logic [CNT_W-1:0] end_pos, idx_inc, sh_dec;
	logic             out_load;

	// shared units
	pasi_pkg::diff_t  mul_a, mul_b;
	pasi_pkg::prod_t  mul_prod;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [2*CW-1:0]  ram_wdata, ram_rdata;

	assign in_op   = s_tuser;
	assign in_x    = s_tdata[24:0];
	assign in_y    = s_tdata[49:25];
	assign in_ridx = s_tdata[53:50];

	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign ridx_ext = CMP_W'(in_ridx);
	assign rd_ok    = (ridx_ext < CMP_W'(count_q)) && (ridx_ext < CMP_W'(MAX_VERTICES));

	assign idx_inc  = idx_q + CNT_W'(1);
	assign idx_last = (idx_inc == count_q);
	assign full     = (count_q == CNT_W'(MAX_VERTICES));
	assign sh_dec   = sh_q - CNT_W'(1);
	assign end_pos  = ahead ? count_q : idx_q;
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	// ordering of stored entry a against new point b
	always_comb begin
		decide = 1'b0;
		ahead  = 1'b0;
		unique case (state_q)
			S_CMP: begin
				if (!same_q) begin
					if (!ay_q[DW-1] && by_q[DW-1]) begin
						decide = 1'b1;
						ahead  = 1'b1;
					end else if (ay_q[DW-1] && !by_q[DW-1]) begin
						decide = 1'b1;
						ahead  = 1'b0;
					end else if (ay_q == '0 && by_q == '0) begin
						// both on the x axis
						decide = 1'b1;
						if ((!ax_q[DW-1] && ax_q != '0) || (!bx_q[DW-1] && bx_q != '0)) begin
							ahead = (ax_q < bx_q);
						end else begin
							ahead = (ax_q > bx_q);
						end
					end
				end
			end
			S_X2: begin
				decide = (t_q != mul_prod);
				ahead  = (t_q > mul_prod);
			end
			S_M3: begin
				decide = 1'b1;
				ahead  = (ma_q < mb_q);
			end
			default: begin
				decide = 1'b0;
				ahead  = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		unique case (state_q) inside
			S_IDLE: begin
				if (in_fire) begin
					case (in_op)
						pasi_pkg::OP_CLEAR: begin
							state_d = S_DONE;
							count_d = '0;
						end
						pasi_pkg::OP_INSERT: state_d = (count_q == '0) ? S_PLACE : S_MB0;
						pasi_pkg::OP_READ:   state_d = rd_ok ? S_RDWAIT : S_DONE;
						default:             state_d = S_DONE;
					endcase
				end
			end
			S_MB0: state_d = S_MB1;
			S_MB1: state_d = S_MB2;
			S_MB2: state_d = S_RD;
			S_RD:  state_d = S_LD;
			S_LD:  state_d = S_CMP;
			S_CMP, S_X2, S_M3: begin
				if (state_q == S_CMP && same_q) begin
					state_d = S_DONE;
				end else if (decide) begin
					if (ahead && !idx_last) state_d = S_RD;
					else if (full)          state_d = S_DONE;
					else if (end_pos == count_q) state_d = S_PLACE;
					else                    state_d = S_SH_RD;
				end else begin
					state_d = (state_q == S_CMP) ? S_X1 : S_M1;
				end
			end
			S_X1:     state_d = S_X2;
			S_M1:     state_d = S_M2;
			S_M2:     state_d = S_M3;
			S_SH_RD:  state_d = S_SH_WR;
			S_SH_WR:  state_d = (sh_dec == ins_pos_q) ? S_PLACE : S_SH_RD;
			S_PLACE: begin
				state_d = S_DONE;
				count_d = count_q + CNT_W'(1);
			end
			S_RDWAIT: state_d = S_DONE;
			S_DONE:   state_d = out_load ? S_IDLE : S_DONE;
			default:  state_d = S_IDLE;
		endcase
	end

	// multiplier operand select
	always_comb begin
		unique case (state_q)
			S_MB0: begin mul_a = bx_q; mul_b = bx_q; end
			S_MB1: begin mul_a = by_q; mul_b = by_q; end
			S_CMP: begin mul_a = ax_q; mul_b = by_q; end
			S_X1:  begin mul_a = ay_q; mul_b = bx_q; end
			S_X2:  begin mul_a = ax_q; mul_b = ax_q; end
			S_M1:  begin mul_a = ay_q; mul_b = ay_q; end
			default: begin mul_a = ax_q; mul_b = by_q; end
		endcase
	end

	// RAM port select; words hold {y, x}
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sh_q[AW-1:0];
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_IDLE:  ram_raddr = ridx_ext[AW-1:0];
			S_SH_RD: ram_raddr = sh_dec[AW-1:0];
			default: ram_raddr = idx_q[AW-1:0];
		endcase
		if (state_q == S_SH_WR) begin
			ram_we = 1'b1;
		end else if (state_q == S_PLACE) begin
			ram_we    = 1'b1;
			ram_waddr = ins_pos_q[AW-1:0];
			ram_wdata = {py_q, px_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
			cx_q       <= '0;
			cy_q       <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (cfg_wr_en) begin
				if (cfg_index == pasi_pkg::REG_CENTER_Y) cy_q <= cfg_data;
				else                                     cx_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q) inside
			S_IDLE: begin
				px_q      <= in_x;
				py_q      <= in_y;
				bx_q      <= $signed({1'b0, in_x}) - $signed({1'b0, cx_q});
				by_q      <= $signed({1'b0, in_y}) - $signed({1'b0, cy_q});
				idx_q     <= '0;
				ins_pos_q <= '0;
				res_x_q   <= '0;
				res_y_q   <= '0;
				res_pos_q <= '0;
				case (in_op)
					pasi_pkg::OP_CLEAR: res_status_q <= pasi_pkg::ST_CLEARED;
					pasi_pkg::OP_INSERT: res_status_q <= pasi_pkg::ST_INSERTED;
					pasi_pkg::OP_READ: begin
						res_status_q <= rd_ok ? pasi_pkg::ST_READ_OK : pasi_pkg::ST_BEYOND;
						res_pos_q    <= ridx_ext;
					end
					default: res_status_q <= pasi_pkg::ST_BEYOND;
				endcase
			end
			S_RDWAIT: begin
				res_x_q <= ram_rdata[CW-1:0];
				res_y_q <= ram_rdata[2*CW-1:CW];
			end
			S_MB1, S_X1, S_M1: t_q <= mul_prod;
			S_MB2: mb_q <= pasi_pkg::PROD_W'($unsigned(t_q) + $unsigned(mul_prod));
			S_M2:  ma_q <= pasi_pkg::PROD_W'($unsigned(t_q) + $unsigned(mul_prod));
			S_LD: begin
				ax_q   <= $signed({1'b0, ram_rdata[CW-1:0]}) - $signed({1'b0, cx_q});
				ay_q   <= $signed({1'b0, ram_rdata[2*CW-1:CW]}) - $signed({1'b0, cy_q});
				same_q <= (ram_rdata == {py_q, px_q});
			end
			S_SH_WR: sh_q <= sh_dec;
			S_PLACE: begin
				res_status_q <= pasi_pkg::ST_INSERTED;
				res_pos_q    <= CMP_W'(ins_pos_q);
			end
			default: begin
			end
		endcase

		if (state_q == S_CMP && same_q) begin
			res_status_q <= pasi_pkg::ST_DUPLICATE;
			res_pos_q    <= CMP_W'(idx_q);
		end else if (decide) begin
			if (ahead && !idx_last) begin
				idx_q <= idx_inc;
			end else begin
				ins_pos_q <= end_pos;
				sh_q      <= count_q;
				if (full) begin
					res_status_q <= pasi_pkg::ST_FULL;
					res_pos_q    <= '0;
				end
			end
		end

		if (out_load) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= {4'b0, res_y_q, res_x_q,
			              pasi_pkg::OUT_IDX_W'(count_q), pasi_pkg::OUT_IDX_W'(res_pos_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	pasi_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	pasi_ram #(
		.WIDTH (2 * CW),
		.DEPTH (MAX_VERTICES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count above table size");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_LD || state_q == S_CMP) |-> idx_q < count_q)
		else $error("scan index beyond vertex count");

	a_place_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE || state_q == S_SH_WR) |-> !full)
		else $error("table write with the table full");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word taken while busy");

endmodule
`default_nettype wire

@@ sv/pasi_ram.sv @@
// Generic single write port RAM with one registered read port.
`default_nettype none
module pasi_ram #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ sv/pasi_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none
module pasi_mul (
	input  wire logic          clk,
	input  wire pasi_pkg::diff_t a,
	input  wire pasi_pkg::diff_t b,
	output      pasi_pkg::prod_t prod
);

	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule
`default_nettype wire
